@@ rtl/cdg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared constants and types for the central-difference gradient core.
// ----------------------------------------------------------------------------
package cdg_pkg;

  localparam int GRID_COLS = 9;
  localparam int GRID_ROWS = 9;

  localparam int SAMPLE_W = 24;
  localparam int GRAD_W   = 25;
  localparam int IDX_W    = 7;

  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int HIST_D = 2 * GRID_COLS;

  // queue between the front and back halves
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one square's worth of border-resolved neighbours
  typedef struct packed {
    sample_t          right;
    sample_t          left;
    sample_t          down;
    sample_t          up;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cdg_task_t;

endpackage

@@ rtl/cdg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_front
// Takes samples, keeps the two-row window and resolves border neighbours.
// ----------------------------------------------------------------------------
module cdg_front import cdg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  sample_t   in_sample,
  output logic      in_ready,
  input  logic      q_full,
  output logic      push,
  output cdg_task_t task_o
);

  sample_t          window_r [HIST_D];
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             flushing_r, flushing_nxt;

  logic    accept, flush_step, shift;
  logic    col_first, col_last, grid_end;
  sample_t self_v;

  assign col_first  = (col_r == '0);
  assign col_last   = (col_r == COL_W'(GRID_COLS - 1));
  assign grid_end   = col_last && (row_r == ROW_W'(GRID_ROWS - 1));

  assign in_ready   = !flushing_r && !q_full;
  assign accept     = in_valid && in_ready;
  assign flush_step = flushing_r && !q_full;
  assign shift      = accept || flush_step;
  assign push       = (accept && (row_r != '0)) || flush_step;

  // square under work is one row back from the newest word (or the flush slot)
  assign self_v = window_r[GRID_COLS-1];

  always_comb begin
    task_o.right = col_last  ? self_v : window_r[(GRID_COLS > 1) ? GRID_COLS-2 : 0];
    task_o.left  = col_first ? self_v : window_r[GRID_COLS];
    task_o.down  = flushing_r ? self_v : in_sample;
    task_o.up    = (!flushing_r && (row_r == ROW_W'(1))) ? self_v : window_r[HIST_D-1];
    task_o.idx   = idx_r;
    task_o.last  = flushing_r ? col_last : !grid_end;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      window_r[0] <= accept ? in_sample : '0;
      for (int k = 1; k < HIST_D; k++) begin
        window_r[k] <= window_r[k-1];
      end
    end
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    flushing_nxt = flushing_r;
    idx_nxt      = idx_r;
    if (accept) begin
      if (grid_end) begin
        col_nxt      = '0;
        row_nxt      = '0;
        flushing_nxt = 1'b1;
      end else if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (flush_step) begin
      if (col_last) begin
        col_nxt      = '0;
        flushing_nxt = 1'b0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (flush_step && col_last) begin
      idx_nxt = '0;
    end else if (push) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      idx_r      <= '0;
      flushing_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      idx_r      <= idx_nxt;
      flushing_r <= flushing_nxt;
    end
  end

endmodule

@@ rtl/cdg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_fifo
// Short queue of resolved squares between the front and back halves.
// ----------------------------------------------------------------------------
module cdg_fifo import cdg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cdg_task_t push_data,
  input  logic      pop,
  output cdg_task_t pop_data,
  output logic      full,
  output logic      empty
);

  cdg_task_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/cdg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_back
// Forms the two differences and holds the result word for the output port.
// ----------------------------------------------------------------------------
module cdg_back import cdg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  cdg_task_t                q_data,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GRAD_W-1:0] out_grad_x,
  output logic signed [GRAD_W-1:0] out_grad_y,
  output logic [IDX_W-1:0]         out_square_index,
  output logic                     out_run_last
);

  logic                     valid_r, valid_nxt;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     last_r;

  // Q.8 difference read as Q.9 is exactly half the difference
  logic signed [GRAD_W-1:0] gx_nxt, gy_nxt;

  assign pop    = !q_empty && (!valid_r || out_ready);
  assign gx_nxt = GRAD_W'(q_data.right) - GRAD_W'(q_data.left);
  assign gy_nxt = GRAD_W'(q_data.down)  - GRAD_W'(q_data.up);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      idx_r  <= q_data.idx;
      last_r <= q_data.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_grad_x       = gx_r;
  assign out_grad_y       = gy_r;
  assign out_square_index = idx_r;
  assign out_run_last     = last_r;

endmodule

@@ rtl/grid_central_difference_gradient_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_central_difference_gradient_core
// Central-difference gradient over a raster-scanned grid, replicate border.
// ----------------------------------------------------------------------------
// Samples (Q.8) arrive in raster order, one word per cycle while in_ready
// is high. Each square's gradient (Q.9, exact) is produced once the sample
// below it has arrived, so from the second row on every accepted word yields
// one result word. The last sample of a grid starts a flush of GRID_COLS
// further results for the bottom row, one per cycle while the queue is not
// full, during which in_ready is low. The front half keeps a two-row sample
// window in registers and resolves the border neighbours, a four-entry queue
// decouples it from the back half, which forms the two differences into a
// registered output. From accept to out_valid a square passes through a
// queue entry and then the output register.
// ----------------------------------------------------------------------------
module grid_central_difference_gradient_core import cdg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [GRAD_W-1:0]   out_grad_x,
  output logic signed [GRAD_W-1:0]   out_grad_y,
  output logic [IDX_W-1:0]           out_square_index,
  output logic                       out_run_last
);

  cdg_task_t push_data, pop_data;
  logic      push, pop, q_full, q_empty;

  cdg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .push      (push),
    .task_o    (push_data)
  );

  cdg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cdg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_square_index (out_square_index),
    .out_run_last     (out_run_last)
  );

endmodule

@@ test/grid_gradient_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_gradient_checker
// Watches both channels of the gradient core, predicts every result word from
// the accepted samples and compares each one, field by field, in order.
// ----------------------------------------------------------------------------
module grid_gradient_checker import cdg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [GRAD_W-1:0]   out_grad_x,
  input  logic signed [GRAD_W-1:0]   out_grad_y,
  input  logic [IDX_W-1:0]           out_square_index,
  input  logic                       out_run_last,
  output int                         fail_count,
  output int                         pending
);

  localparam int GRID_SIZE = GRID_COLS * GRID_ROWS;

  typedef struct {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [IDX_W-1:0]         square_idx;
    logic                     run_last;
  } square_grad_t;

  sample_t      grid_samples [GRID_SIZE];
  int           next_pos;
  square_grad_t pending_gradients [$];

  // every neighbour read here belongs to the current grid and is already stored
  function automatic square_grad_t predict_square(int s, bit last);
    int           row;
    int           col;
    sample_t      self_v;
    sample_t      right_v;
    sample_t      left_v;
    sample_t      down_v;
    sample_t      up_v;
    square_grad_t g;
    row     = s / GRID_COLS;
    col     = s % GRID_COLS;
    self_v  = grid_samples[s];
    right_v = (col + 1 < GRID_COLS) ? grid_samples[s + 1] : self_v;
    left_v  = (col > 0) ? grid_samples[s - 1] : self_v;
    down_v  = (row + 1 < GRID_ROWS) ? grid_samples[s + GRID_COLS] : self_v;
    up_v    = (row > 0) ? grid_samples[s - GRID_COLS] : self_v;
    // Q.8 difference halved is Q.9: the raw difference, one bit wider
    g.grad_x     = $signed({right_v[SAMPLE_W-1], right_v}) - $signed({left_v[SAMPLE_W-1], left_v});
    g.grad_y     = $signed({down_v[SAMPLE_W-1], down_v}) - $signed({up_v[SAMPLE_W-1], up_v});
    g.square_idx = IDX_W'(s);
    g.run_last   = last;
    return g;
  endfunction

  always @(posedge clk) begin
    square_grad_t exp_g;
    bit           grid_done;
    if (!rst_n) begin
      next_pos   = 0;
      fail_count = 0;
      pending_gradients.delete();
    end else begin
      // result side first: a word leaving now never stems from a sample taken now
      if (out_valid && out_ready) begin
        if (pending_gradients.size() == 0) begin
          $display("%0t: unexpected result word, square %0d grad_x %0d grad_y %0d",
                   $time, out_square_index, out_grad_x, out_grad_y);
          fail_count++;
        end else begin
          exp_g = pending_gradients.pop_front();
          if (exp_g.grad_x !== out_grad_x) begin
            $display("%0t: square %0d grad_x expected %0d got %0d",
                     $time, exp_g.square_idx, exp_g.grad_x, out_grad_x);
            fail_count++;
          end
          if (exp_g.grad_y !== out_grad_y) begin
            $display("%0t: square %0d grad_y expected %0d got %0d",
                     $time, exp_g.square_idx, exp_g.grad_y, out_grad_y);
            fail_count++;
          end
          if (exp_g.square_idx !== out_square_index) begin
            $display("%0t: square_index expected %0d got %0d",
                     $time, exp_g.square_idx, out_square_index);
            fail_count++;
          end
          if (exp_g.run_last !== out_run_last) begin
            $display("%0t: square %0d run_last expected %0d got %0d",
                     $time, exp_g.square_idx, exp_g.run_last, out_run_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        grid_done = (next_pos + 1 >= GRID_SIZE);
        grid_samples[next_pos] = in_sample;
        if (next_pos >= GRID_COLS)
          pending_gradients.push_back(predict_square(next_pos - GRID_COLS, !grid_done));
        // last sample of the grid flushes the bottom row
        if (grid_done) begin
          for (int s = next_pos - GRID_COLS + 1; s <= next_pos; s++)
            pending_gradients.push_back(predict_square(s, s == next_pos));
        end
        next_pos = grid_done ? 0 : next_pos + 1;
      end
    end
    pending = pending_gradients.size();
  end

endmodule

@@ test/grid_central_difference_gradient_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_central_difference_gradient_core_test
// Streams two full grids and part of a third through the gradient core with
// random gaps on both sides; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module grid_central_difference_gradient_core_test;
  import cdg_pkg::*;

  localparam int GRID_SIZE   = GRID_COLS * GRID_ROWS;
  localparam int NUM_SAMPLES = 2 * GRID_SIZE + 20;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 64;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = sample_t'(24'h800000);

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [GRAD_W-1:0]   out_grad_x;
  logic signed [GRAD_W-1:0]   out_grad_y;
  logic [IDX_W-1:0]           out_square_index;
  logic                       out_run_last;

  int fail_count;
  int pending;
  int items_sent;
  bit calm;
  bit hold_done;

  grid_central_difference_gradient_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_square_index (out_square_index),
    .out_run_last     (out_run_last)
  );

  grid_gradient_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_square_index (out_square_index),
    .out_run_last     (out_run_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // opening of the first grid: checkerboard of the extremes, then odd values
  function automatic sample_t directed_sample(int i);
    if (i < 2 * GRID_COLS)
      return (((i % GRID_COLS) + (i / GRID_COLS)) % 2) ? SAMPLE_MIN : SAMPLE_MAX;
    case (i - 2 * GRID_COLS)
      0:       return '0;
      1:       return -24'sd1;
      2:       return 24'sd1;
      3:       return SAMPLE_MAX;
      4:       return SAMPLE_MIN;
      5:       return 24'sd256;
      default: return -24'sd256;
    endcase
  endfunction

  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SAMPLE_MAX;
    if (r == 1) return SAMPLE_MIN;
    if (r < 5) return sample_t'($urandom_range(0, 1023) - 512);
    return sample_t'($urandom());
  endfunction

  task automatic send_sample(sample_t v);
    in_sample <= v;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // sender, reset and verdict
  initial begin
    int gap;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      calm = (i >= 30 && i < 70);
      send_sample((i < 25) ? directed_sample(i) : random_sample());
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver
  initial begin
    int stall_left;
    int n;
    out_ready  = 1'b0;
    hold_done  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        // long hold-off while the sender keeps offering: fills the core up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        n = idle_len();
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = n - 1;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
